@@ rtl/cba_pkg.sv @@
`default_nettype none
package cba_pkg;

    // Disk geometry and derived widths
    localparam int DISK_BLOCKS = 128;
    localparam int IDX_W       = $clog2(DISK_BLOCKS);
    localparam int CNT_W       = $clog2(DISK_BLOCKS + 1);

    // Request and result field widths
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 8;
    localparam int START_W  = 7;
    localparam int STATUS_W = 2;
    localparam int FIRST_W  = 7;
    localparam int DONE_W   = 8;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - (STATUS_W + FIRST_W + DONE_W);

    typedef enum logic [OP_W-1:0] {
        OP_CONTIG  = 2'd0,
        OP_SCATTER = 2'd1,
        OP_FREE    = 2'd2,
        OP_COMPACT = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADCOUNT = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic check;
        logic scan;
        logic write;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic bad;
        logic is_free;
        logic range_empty;
        logic scan_go;
        logic scan_stop;
        logic write_last;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ rtl/cba_datapath.sv @@
`default_nettype none
module cba_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cba_pkg::t_dp_cmd            i_cmd,
    input  wire cba_pkg::t_op                i_op,
    input  wire logic [cba_pkg::COUNT_W-1:0] i_count,
    input  wire logic [cba_pkg::START_W-1:0] i_start_req,
    output cba_pkg::t_dp_stat                o_stat,
    output cba_pkg::t_status                 o_status,
    output logic [cba_pkg::FIRST_W-1:0]      o_first_blk,
    output logic [cba_pkg::DONE_W-1:0]       o_blocks_done
);
    import cba_pkg::*;

    logic r_map [DISK_BLOCKS];
    logic r_bit;

    t_op                r_op;
    logic [COUNT_W-1:0] r_cnt;
    logic [START_W-1:0] r_start;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [CNT_W-1:0]   r_run;
    logic [IDX_W-1:0]   r_run_start;
    logic [CNT_W-1:0]   r_tally;
    logic [CNT_W-1:0]   r_wr_left;
    t_status            r_status;
    logic [FIRST_W-1:0] r_first;
    logic [DONE_W-1:0]  r_done;

    logic             w_bit;
    logic             w_last;
    logic [CNT_W-1:0] w_cnt;
    logic [CNT_W-1:0] w_run_nx;
    logic [IDX_W-1:0] w_run_start_eff;
    logic             w_hit;
    logic [CNT_W-1:0] w_tally_nx;
    logic             w_enough;
    logic             w_scan_go;
    logic             w_bad;
    logic             w_range_empty;
    logic [CNT_W-1:0] w_avail;
    logic [CNT_W-1:0] w_free_n;
    logic             w_take;

    always_comb begin
        // Registered read, addressed ahead with the next index
        w_bit           = r_bit;
        w_last          = (r_idx == IDX_W'(DISK_BLOCKS - 1));
        w_cnt           = CNT_W'(r_cnt);
        w_run_nx        = r_run + CNT_W'(1);
        w_run_start_eff = (r_run == '0) ? r_idx : r_run_start;
        w_hit           = (r_op == OP_CONTIG) && !w_bit && (w_run_nx == w_cnt);
        // Count occupied blocks for compaction, free blocks otherwise
        w_tally_nx      = r_tally + CNT_W'((r_op == OP_COMPACT) ? w_bit : !w_bit);
        w_enough        = (w_tally_nx >= w_cnt);
        w_scan_go       = w_hit || (w_last && (((r_op == OP_SCATTER) && w_enough)
                                               || (r_op == OP_COMPACT)));
        w_bad           = (r_op != OP_COMPACT)
                          && ((r_cnt == '0) || (32'(r_cnt) > DISK_BLOCKS));
        w_range_empty   = (32'(r_start) >= DISK_BLOCKS);
        w_avail         = CNT_W'(DISK_BLOCKS - 32'(r_start));
        w_free_n        = (w_cnt < w_avail) ? w_cnt : w_avail;
        // A scattered write lands only on free blocks
        w_take          = (r_op != OP_SCATTER) || !w_bit;

        n_idx = r_idx;
        if (i_cmd.clear || i_cmd.write) begin
            n_idx = r_idx + IDX_W'(1);
        end else if (i_cmd.check) begin
            n_idx = (!w_bad && (r_op == OP_FREE)) ? IDX_W'(r_start) : '0;
        end else if (i_cmd.scan) begin
            if (w_hit) begin
                // Rewind to the run and mark it
                n_idx = w_run_start_eff;
            end else if (w_last) begin
                n_idx = '0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    assign o_stat.clear_last  = w_last;
    assign o_stat.bad         = w_bad;
    assign o_stat.is_free     = (r_op == OP_FREE);
    assign o_stat.range_empty = w_range_empty;
    assign o_stat.scan_go     = w_scan_go;
    assign o_stat.scan_stop   = w_last && !w_scan_go;
    assign o_stat.write_last  = (r_wr_left == CNT_W'(1)) && w_take;

    assign o_status      = r_status;
    assign o_first_blk   = r_first;
    assign o_blocks_done = r_done;

    // Occupancy bitmap: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_map[r_idx] <= 1'b0;
        end else if (i_cmd.write) begin
            unique case (r_op)
                OP_CONTIG:  r_map[r_idx] <= 1'b1;
                OP_SCATTER: r_map[r_idx] <= 1'b1;
                OP_FREE:    r_map[r_idx] <= 1'b0;
                OP_COMPACT: r_map[r_idx] <= (CNT_W'(r_idx) < r_tally);
                default:    r_map[r_idx] <= w_bit;
            endcase
        end
        r_bit <= r_map[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_cnt   <= i_count;
            r_start <= i_start_req;
        end

        if (i_cmd.check) begin
            r_run   <= '0;
            r_tally <= '0;
            if (w_bad) begin
                r_status <= ST_BADCOUNT;
                r_first  <= '0;
                r_done   <= '0;
            end else if (r_op == OP_FREE) begin
                r_wr_left <= w_free_n;
                r_status  <= ST_OK;
                r_first   <= '0;
                r_done    <= w_range_empty ? '0 : DONE_W'(w_free_n);
            end
        end

        if (i_cmd.scan) begin
            r_tally     <= w_tally_nx;
            r_run       <= w_bit ? '0 : w_run_nx;
            r_run_start <= w_run_start_eff;
            if (w_hit) begin
                r_wr_left <= w_cnt;
                r_status  <= ST_OK;
                r_first   <= FIRST_W'(w_run_start_eff);
                r_done    <= DONE_W'(w_cnt);
            end else if (w_last) begin
                r_first <= '0;
                if (r_op == OP_COMPACT) begin
                    r_wr_left <= CNT_W'(DISK_BLOCKS);
                    r_status  <= ST_OK;
                    r_done    <= DONE_W'(w_tally_nx);
                end else if ((r_op == OP_SCATTER) && w_enough) begin
                    r_wr_left <= w_cnt;
                    r_status  <= ST_OK;
                    r_done    <= DONE_W'(w_cnt);
                end else begin
                    r_status <= ST_FULL;
                    r_done   <= '0;
                end
            end
        end

        if (i_cmd.write) begin
            if (w_take) begin
                r_wr_left <= r_wr_left - CNT_W'(1);
            end
            // First free block taken by a scattered allocation
            if ((r_op == OP_SCATTER) && !w_bit && (r_wr_left == w_cnt)) begin
                r_first <= FIRST_W'(r_idx);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/cba_ctrl.sv @@
`default_nettype none
module cba_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    input  wire cba_pkg::t_dp_stat i_stat,
    output cba_pkg::t_dp_cmd       o_cmd
);
    import cba_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_SCAN  = 6'b000100,
        S_WRITE = 6'b001000,
        S_DONE  = 6'b010000,
        S_CLEAR = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_s_ready   = 1'b0;
        o_m_valid   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                // Wipe the bitmap one block per cycle
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.bad) begin
                    n_state = S_DONE;
                end else if (i_stat.is_free) begin
                    n_state = i_stat.range_empty ? S_DONE : S_WRITE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_go) begin
                    n_state = S_WRITE;
                end else if (i_stat.scan_stop) begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                if (i_stat.write_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_m_valid = 1'b1;
                if (i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ rtl/contiguous_block_allocator_top.sv @@
// Channel   Direction  Handshake               Payload
// request   in         i_s_tvalid/o_s_tready   i_s_tuser = op, i_s_tdata = count, start_req
// result    out        o_m_tvalid/i_m_tready   o_m_tdata = status, first_blk, blocks_done
//
// One request is in flight at a time. A request is accepted, then checked, then
// the bitmap is scanned over up to DISK_BLOCKS blocks (one block per cycle
// through a single registered read port), then a write pass marks or clears up
// to DISK_BLOCKS blocks. A free skips the scan; a bad count skips both scan and
// write pass. After reset the bitmap is cleared one block per cycle, with
// o_s_tready low. The result holds in its register until taken; a stalled
// result blocks new requests.
`default_nettype none
module contiguous_block_allocator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [7:0] count, [14:8] start_req, [15] zero
    input  wire logic [cba_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] op
    input  wire logic [cba_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [1:0] status, [8:2] first_blk, [16:9] blocks_done, [23:17] zero
    output logic [cba_pkg::M_TDATA_W-1:0]      o_m_tdata
);
    import cba_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    t_status            w_status;
    logic [FIRST_W-1:0] w_first_blk;
    logic [DONE_W-1:0]  w_blocks_done;

    // Sequencer: owns the handshakes and steps the datapath
    cba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // Bitmap, scan counters and result registers
    cba_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_op          (t_op'(i_s_tuser)),
        .i_count       (i_s_tdata[COUNT_W-1:0]),
        .i_start_req   (i_s_tdata[COUNT_W +: START_W]),
        .o_stat        (w_stat),
        .o_status      (w_status),
        .o_first_blk   (w_first_blk),
        .o_blocks_done (w_blocks_done)
    );

    // Pack the result, status in the low bits
    assign o_m_tdata = {{M_PAD_W{1'b0}}, w_blocks_done, w_first_blk, w_status};

endmodule
`default_nettype wire

@@ tb/sv/alloc_result_checker.sv @@
`timescale 1ns / 1ps
module alloc_result_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    input  wire logic                          i_s_tready,
    // [7:0] count, [14:8] start_req, [15] zero
    input  wire logic [cba_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] op
    input  wire logic [cba_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  wire logic                          i_m_tvalid,
    input  wire logic                          i_m_tready,
    // [1:0] status, [8:2] first_blk, [16:9] blocks_done, [23:17] zero
    input  wire logic [cba_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import cba_pkg::*;

    typedef struct packed {
        t_status              status;
        logic [FIRST_W-1:0]   first_blk;
        logic [DONE_W-1:0]    blocks_done;
    } t_alloc_result;

    logic [DISK_BLOCKS-1:0] disk_map;
    t_alloc_result          expected_results[$];
    t_alloc_result          want;
    t_alloc_result          got;
    int                     mismatches = 0;

    // Apply one request to the shadow bitmap and work out its result.
    task automatic predict_request(input t_op op, input logic [COUNT_W-1:0] cnt,
                                   input logic [START_W-1:0] start,
                                   output t_alloc_result res);
        int run_len;
        int run_first;
        int occ_total;
        int granted;
        int span;
        bit found;
        res.status      = ST_OK;
        res.first_blk   = '0;
        res.blocks_done = '0;
        run_len   = 0;
        run_first = 0;
        granted   = 0;
        found     = 1'b0;
        occ_total = $countones(disk_map);
        if (op == OP_COMPACT) begin
            for (int i = 0; i < DISK_BLOCKS; i++)
                disk_map[i] = (i < occ_total);
            res.blocks_done = occ_total[DONE_W-1:0];
        end else if (cnt == 0 || int'(cnt) > DISK_BLOCKS) begin
            res.status = ST_BADCOUNT;
        end else begin
            case (op)
                OP_CONTIG: begin
                    for (int i = 0; i < DISK_BLOCKS && !found; i++) begin
                        if (disk_map[i]) begin
                            run_len = 0;
                        end else begin
                            if (run_len == 0)
                                run_first = i;
                            run_len++;
                            if (run_len == int'(cnt))
                                found = 1'b1;
                        end
                    end
                    if (found) begin
                        for (int j = run_first; j < run_first + int'(cnt); j++)
                            disk_map[j] = 1'b1;
                        res.first_blk   = run_first[FIRST_W-1:0];
                        res.blocks_done = cnt;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
                OP_SCATTER: begin
                    if (DISK_BLOCKS - occ_total < int'(cnt)) begin
                        res.status = ST_FULL;
                    end else begin
                        for (int i = 0; i < DISK_BLOCKS && granted < int'(cnt); i++) begin
                            if (!disk_map[i]) begin
                                if (granted == 0)
                                    res.first_blk = i[FIRST_W-1:0];
                                disk_map[i] = 1'b1;
                                granted++;
                            end
                        end
                        res.blocks_done = granted[DONE_W-1:0];
                    end
                end
                default: begin
                    // Free range, clipped at the end of the disk.
                    span = 0;
                    if (int'(start) < DISK_BLOCKS) begin
                        span = DISK_BLOCKS - int'(start);
                        if (int'(cnt) < span)
                            span = int'(cnt);
                        for (int i = 0; i < span; i++)
                            disk_map[int'(start) + i] = 1'b0;
                    end
                    res.blocks_done = span[DONE_W-1:0];
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            disk_map = '0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status      = t_status'(i_m_tdata[STATUS_W-1:0]);
                got.first_blk   = i_m_tdata[STATUS_W +: FIRST_W];
                got.blocks_done = i_m_tdata[STATUS_W + FIRST_W +: DONE_W];
                if (expected_results.size() == 0) begin
                    $error("result with no request waiting: tdata %h", i_m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.first_blk !== want.first_blk) begin
                        $error("first_blk: expected %0d, got %0d",
                               want.first_blk, got.first_blk);
                        mismatches++;
                    end
                    if (got.blocks_done !== want.blocks_done) begin
                        $error("blocks_done: expected %0d, got %0d",
                               want.blocks_done, got.blocks_done);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_request(t_op'(i_s_tuser), i_s_tdata[COUNT_W-1:0],
                                i_s_tdata[COUNT_W +: START_W], want);
                expected_results.push_back(want);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/sv/tb_contiguous_block_allocator_top.sv @@
`timescale 1ns / 1ps
module tb_contiguous_block_allocator_top;
    import cba_pkg::*;

    // Room for the slowest request, a full scan then a full write pass; allow margin.
    localparam int DRAIN_CYCLES  = 2 * DISK_BLOCKS + 40;
    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int RANDOM_ITEMS  = 1530;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 3;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    // [7:0] count, [14:8] start_req, [15] zero
    logic [S_TDATA_W-1:0] s_tdata    = '0;
    // [1:0] op
    logic [S_TUSER_W-1:0] s_tuser    = '0;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    // [1:0] status, [8:2] first_blk, [16:9] blocks_done, [23:17] zero
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int tx_idle_pct = 35;
    int rx_idle_pct = 81;

    contiguous_block_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    alloc_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock: low half, then high half.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: stall at random with the current idle rate.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Present one request, with a random lead-in gap, and hold it until taken.
    // Valid is left high on acceptance so back-to-back requests need no dip.
    task automatic send_request(input t_op op, input int cnt, input int start);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, start[START_W-1:0], cnt[COUNT_W-1:0]};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    // Drop valid and hold off until every outstanding request has its result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Mostly small sizes so the bitmap fragments and refills; a few large ones,
    // occasional compaction and some out-of-range counts as noise.
    task automatic send_random_request();
        int pick;
        int cnt;
        int start;
        pick  = $urandom_range(0, 99);
        start = $urandom_range(0, DISK_BLOCKS - 1);
        if ($urandom_range(0, 9) == 0)
            cnt = $urandom_range(1, DISK_BLOCKS);
        else
            cnt = $urandom_range(1, 12);
        if (pick < 38) begin
            send_request(OP_CONTIG, cnt, start);
        end else if (pick < 62) begin
            send_request(OP_SCATTER, cnt, start);
        end else if (pick < 88) begin
            if ($urandom_range(0, 3) == 0)
                cnt = $urandom_range(1, DISK_BLOCKS);
            else
                cnt = $urandom_range(1, 24);
            send_request(OP_FREE, cnt, start);
        end else if (pick < 93) begin
            send_request(OP_COMPACT, $urandom_range(0, 255), start);
        end else begin
            cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(DISK_BLOCKS + 1, 255);
            send_request(t_op'($urandom_range(0, 2)), cnt, start);
        end
    endtask

    // Timeout guard.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad counts on each counted op.
        send_request(OP_CONTIG, 0, 0);
        send_request(OP_SCATTER, DISK_BLOCKS + 1, 0);
        send_request(OP_FREE, 255, DISK_BLOCKS - 1);
        // Fill the whole disk, then hit the full cases for both allocators.
        send_request(OP_CONTIG, DISK_BLOCKS, 0);
        send_request(OP_CONTIG, 1, 0);
        send_request(OP_SCATTER, 1, 0);
        // Free clipped at the last block, then scatter short by one and exact.
        send_request(OP_FREE, DISK_BLOCKS, DISK_BLOCKS - 1);
        send_request(OP_SCATTER, 2, 0);
        send_request(OP_SCATTER, 1, 0);
        send_request(OP_FREE, DISK_BLOCKS, 0);
        // Punch a hole too short for first fit, then fill it by scattering.
        send_request(OP_CONTIG, 10, 0);
        send_request(OP_CONTIG, 10, 0);
        send_request(OP_FREE, 4, 3);
        send_request(OP_CONTIG, 5, 0);
        send_request(OP_SCATTER, 6, 0);
        // Free blocks that are already free; they still count.
        send_request(OP_FREE, 5, 40);
        // Compaction ignores count and start.
        send_request(OP_COMPACT, 0, DISK_BLOCKS - 1);
        send_request(OP_CONTIG, 101, 0);
        send_request(OP_COMPACT, 200, 0);
        send_request(OP_FREE, 64, 64);
        // One more than the free blocks in total for first fit, then scatter all of them.
        send_request(OP_CONTIG, 65, 0);
        send_request(OP_SCATTER, 64, 0);
        send_request(OP_FREE, DISK_BLOCKS, 0);
        drain_results();

        // Random: three idle profiles, draining at each switch.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 35;
                    rx_idle_pct = 81;
                end
                1: begin
                    tx_idle_pct = 81;
                    rx_idle_pct = 35;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_request();
                if ($urandom_range(0, 199) == 0)
                    drain_results();
            end
            drain_results();
        end

        // Wait out any late or stray result before the verdict.
        s_tvalid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
